### rtl/ilir_pkg.sv
package ilir_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int DATA_W_DEF   = 32;

   localparam int CMD_W   = 3;
   localparam int POS_W   = 7;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_GET    = 3'd1,
      CMD_SET    = 3'd2,
      CMD_REMOVE = 3'd3,
      CMD_CLEAR  = 3'd4
   } cmd_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic             ins;
      logic             rmv;
      logic             set;
      logic [POS_W-1:0] pos;
   } cell_ctrl_type;

endpackage

### rtl/indexed_list_insert_remove_unit.sv
// The response item is registered and follows in the cycle after its request
// is accepted. One item per cycle unless rsp_stall holds a response; every
// entry sits in its own cell; all cells shift in parallel on insert or remove.
// Reset clears the list length and the response valid; the entry cells are
// not reset and hold undefined words until written.
module indexed_list_insert_remove_unit
   import ilir_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int DATA_W   = DATA_W_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_cmd,
   input  logic [POS_W-1:0]   req_position,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_ok,
   output logic [VALUE_W-1:0] rsp_data,
   output logic [COUNT_W-1:0] rsp_count
);

   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;
   localparam int EXT_W = DATA_W + VALUE_W;
   localparam int CNT_X = LEN_W + COUNT_W;

   logic [LEN_W-1:0]   length_ff;
   logic [LEN_W-1:0]   length_in;
   logic               rsp_valid_ff;
   logic               rsp_ok_ff;
   logic               rsp_ok_in;
   logic [VALUE_W-1:0] rsp_data_ff;
   logic [VALUE_W-1:0] rsp_data_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [COUNT_W-1:0] rsp_count_in;

   logic               accept;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   len_ext;
   logic               full;
   logic               in_list;
   cell_ctrl_type      ctrl;
   logic [EXT_W-1:0]   value_ext;
   logic [DATA_W-1:0]  wr_word;
   logic [DATA_W-1:0]  rd_word;
   logic [EXT_W-1:0]   rd_ext;
   logic [CNT_X-1:0]   count_ext;

   logic [DATA_W-1:0]  cell_data [CAPACITY];
   logic [DATA_W-1:0]  cell_rd   [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pos_ext   = CMP_W'(req_position);
   assign len_ext   = CMP_W'(length_ff);
   assign full      = (length_ff == LEN_W'(CAPACITY));
   assign in_list   = pos_ext < len_ext;
   assign value_ext = EXT_W'(req_value);
   assign wr_word   = value_ext[DATA_W-1:0];

   // pick the addressed word: only the hit cell drives nonzero
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end
   assign rd_ext = EXT_W'(rd_word);

   always_comb begin
      ctrl        = '0;
      ctrl.pos    = req_position;
      length_in   = length_ff;
      rsp_ok_in   = 1'b0;
      rsp_data_in = '0;
      case (cmd_type'(req_cmd))
         CMD_INSERT: begin
            if (!full && pos_ext <= len_ext) begin
               ctrl.ins  = accept;
               length_in = length_ff + LEN_W'(1);
               rsp_ok_in = 1'b1;
            end
         end
         CMD_GET: begin
            if (in_list) begin
               rsp_ok_in   = 1'b1;
               rsp_data_in = rd_ext[VALUE_W-1:0];
            end
         end
         CMD_SET: begin
            if (in_list) begin
               ctrl.set    = accept;
               rsp_ok_in   = 1'b1;
               rsp_data_in = rd_ext[VALUE_W-1:0];
            end
         end
         CMD_REMOVE: begin
            if (in_list) begin
               ctrl.rmv    = accept;
               length_in   = length_ff - LEN_W'(1);
               rsp_ok_in   = 1'b1;
               rsp_data_in = rd_ext[VALUE_W-1:0];
            end
         end
         CMD_CLEAR: begin
            length_in = '0;
            rsp_ok_in = 1'b1;
         end
         default: begin
            rsp_ok_in = 1'b0;
         end
      endcase
      count_ext    = CNT_X'(length_in);
      rsp_count_in = count_ext[COUNT_W-1:0];
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] left_d;
      logic [DATA_W-1:0] right_d;
      if (g == 0) begin : g_first
         assign left_d = cell_data[g];
      end else begin : g_mid_l
         assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[g];
      end else begin : g_mid_r
         assign right_d = cell_data[g+1];
      end
      ilir_cell #(
         .DATA_W (DATA_W),
         .IDX    (g)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .wr_data    (wr_word),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[g]),
         .rd_data    (cell_rd[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            length_ff    <= length_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            // drop the item once taken
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff    <= rsp_ok_in;
         rsp_data_ff  <= rsp_data_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_count = rsp_count_ff;

endmodule

### rtl/ilir_cell.sv
module ilir_cell
   import ilir_pkg::*;
#(
   parameter int DATA_W = DATA_W_DEF,
   parameter int IDX    = 0
) (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data,
   output logic [DATA_W-1:0] rd_data
);

   localparam bit               IN_RANGE = IDX < (1 << POS_W);
   localparam logic [POS_W-1:0] IDX_P    = POS_W'(IDX % (1 << POS_W));

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              hit;
   logic              above;

   assign hit   = IN_RANGE && (ctrl.pos == IDX_P);
   assign above = !IN_RANGE || (IDX_P > ctrl.pos);

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (above) begin
            data_in = left_data;
         end else if (hit) begin
            data_in = wr_data;
         end
      end else if (ctrl.rmv) begin
         if (above || hit) begin
            data_in = right_data;
         end
      end else if (ctrl.set && hit) begin
         data_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = data_ff & {DATA_W{hit}};

endmodule

### test/tb.sv
module tb;
   import ilir_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 450;
   localparam int DRAIN_LIMIT  = 1000;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   typedef struct {
      logic               ok;
      logic [VALUE_W-1:0] data;
      logic [COUNT_W-1:0] count;
   } rsp_fields_type;

   // shadow copy of the list plus the responses it still owes
   class list_shadow;
      logic [VALUE_W-1:0] words [CAPACITY_DEF];
      int unsigned        used = 0;
      int unsigned        failures = 0;
      rsp_fields_type     pending_results[$];

      function void apply_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                  logic [VALUE_W-1:0] val);
         rsp_fields_type r;
         int unsigned p;
         int unsigned i;
         r.ok = 1'b0;
         r.data = '0;
         p = pos;
         case (cmd)
            CMD_INSERT: if (p <= used && used < CAPACITY_DEF) begin
               for (i = used; i > p; i--)
                  words[i] = words[i - 1];
               words[p] = val;
               used++;
               r.ok = 1'b1;
            end
            CMD_GET: if (p < used) begin
               r.ok = 1'b1;
               r.data = words[p];
            end
            CMD_SET: if (p < used) begin
               r.ok = 1'b1;
               r.data = words[p];
               words[p] = val;
            end
            CMD_REMOVE: if (p < used) begin
               r.ok = 1'b1;
               r.data = words[p];
               for (i = p; i + 1 < used; i++)
                  words[i] = words[i + 1];
               used--;
            end
            CMD_CLEAR: begin
               used = 0;
               r.ok = 1'b1;
            end
            default: ;
         endcase
         r.count = COUNT_W'(used);
         pending_results.push_back(r);
      endfunction

      function void check_response(logic ok, logic [VALUE_W-1:0] data,
                                   logic [COUNT_W-1:0] count);
         rsp_fields_type want;
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding: ok=%0b data=%h count=%0d",
                   ok, data, count);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         if (ok !== want.ok) begin
            $error("ok: expected %0b, actual %0b", want.ok, ok);
            failures++;
         end
         if (data !== want.data) begin
            $error("data: expected %h, actual %h", want.data, data);
            failures++;
         end
         if (count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, count);
            failures++;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [CMD_W-1:0]   req_cmd = '0;
   logic [POS_W-1:0]   req_position = '0;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_ok;
   logic [VALUE_W-1:0] rsp_data;
   logic [COUNT_W-1:0] rsp_count;

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   list_shadow shadow = new();

   indexed_list_insert_remove_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_ok       (rsp_ok),
      .rsp_data     (rsp_data),
      .rsp_count    (rsp_count)
   );

   always #5 clock = ~clock;

   // receiver: random stall, or a long hold when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.check_response(rsp_ok, rsp_data, rsp_count);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[indexed_list_insert_remove_unit] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [VALUE_W-1:0] val);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_position <= pos;
      req_value <= val;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      shadow.apply_request(cmd, pos, val);
   endtask

   // grow favors inserts so the list reaches capacity; otherwise drain it
   task automatic send_random(input bit grow);
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      int roll;
      int used;
      used = shadow.used;
      roll = $urandom_range(999);
      if (roll < 3) begin
         cmd = CMD_CLEAR;
      end else if (roll < 30) begin
         cmd = CMD_W'($urandom_range((1 << CMD_W) - 1, CMD_CLEAR + 1));
      end else begin
         roll = $urandom_range(99);
         if (roll < (grow ? 60 : 15))
            cmd = CMD_INSERT;
         else if (roll < (grow ? 75 : 30))
            cmd = CMD_GET;
         else if (roll < (grow ? 85 : 40))
            cmd = CMD_SET;
         else
            cmd = CMD_REMOVE;
      end
      roll = $urandom_range(99);
      if (roll < 10)
         pos = POS_W'($urandom_range(POS_MAX));
      else if (roll < 15)
         pos = POS_W'(used + int'(cmd == CMD_INSERT));
      else if (cmd == CMD_INSERT)
         pos = POS_W'($urandom_range(used));
      else if (used > 0)
         pos = POS_W'($urandom_range(used - 1));
      else
         pos = '0;
      send_request(cmd, pos, $urandom());
   endtask

   initial begin
      int n;
      int phase;
      int waited;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty list: every access is out of range
      send_request(CMD_GET, 0, 32'h0);
      send_request(CMD_REMOVE, 0, 32'h0);
      send_request(CMD_SET, 0, 32'hDEADBEEF);
      send_request(CMD_INSERT, 1, 32'h11111111);
      // append, front insert, middle insert
      send_request(CMD_INSERT, 0, 32'h00000000);
      send_request(CMD_INSERT, 1, 32'hFFFFFFFF);
      send_request(CMD_INSERT, 0, 32'hA5A5A5A5);
      send_request(CMD_INSERT, 1, 32'h5A5A5A5A);
      send_request(CMD_GET, 3, 32'h0);
      send_request(CMD_GET, 0, 32'h0);
      send_request(CMD_GET, 4, 32'h0);
      send_request(CMD_SET, 2, 32'h12345678);
      send_request(CMD_REMOVE, 1, 32'h0);
      send_request(CMD_REMOVE, 2, 32'h0);
      send_request(CMD_GET, POS_MAX, 32'hFFFFFFFF);
      send_request(CMD_INSERT, POS_MAX, 32'hFFFFFFFF);
      send_request(CMD_W'(CMD_CLEAR + 1), 0, 32'hFFFFFFFF);
      send_request(CMD_W'(CMD_CLEAR + 2), 1, 32'h0);
      send_request(CMD_W'((1 << CMD_W) - 1), POS_MAX, 32'h0);
      send_request(CMD_CLEAR, POS_MAX, 32'hFFFFFFFF);
      send_request(CMD_GET, 0, 32'h0);
      send_request(CMD_CLEAR, 0, 32'h0);

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
               // hold the receiver off while items keep coming
               hold_requests <= hold_requests + 1;
            end
            1: begin
               idle_pct = 49;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 49;
            end
            default: begin
               idle_pct = 22;
               stall_pct <= 22;
            end
         endcase
         for (n = 0; n < PHASE_ITEMS; n++)
            send_random(((n / (PHASE_ITEMS / 2)) % 2) == 0);
      end

      req_valid <= 1'b0;
      waited = 0;
      while (shadow.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (shadow.pending() != 0)
         $error("%0d responses never arrived", shadow.pending());
      if (shadow.failures == 0 && shadow.pending() == 0)
         $display("[indexed_list_insert_remove_unit] OK");
      else
         $display("[indexed_list_insert_remove_unit] ERROR");
      $finish;
   end

endmodule
